/* hdl/strc_pkg.sv */
// ----------------------------------------------------------------------------
// strc_pkg
// Shared types and constants for the segment/triangle raycaster.
// ----------------------------------------------------------------------------
package strc_pkg;

  localparam int CB     = 24;
  localparam int DW     = CB + 1;
  localparam int PW     = 2 * DW;
  localparam int BW     = 96;
  localparam int D2W    = 160;
  localparam int AW     = 256;
  localparam int NBW    = 7;
  localparam int NBIG   = 78;
  localparam int LW     = 52;
  localparam int EW     = 32;
  localparam int QB     = 26;
  localparam int DET_SH = 32;
  localparam int TN_SH  = 48;
  localparam int CFG_W  = 13;

  localparam logic signed [BW-1:0] EPS_SQ = BW'(1844674407);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic                 go;
    alu_op_t              op;
    logic                 clr;
    logic                 neg;
    logic [NBW-1:0]       nb;
    logic signed [AW-1:0] a;
    logic signed [BW-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic                 busy;
    logic signed [AW-1:0] acc;
    logic [QB-1:0]        quo;
  } alu_stat_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  typedef struct packed {
    logic                 operation;
    logic [11:0]          triangle_index;
    logic signed [CB-1:0] p_x;
    logic signed [CB-1:0] p_y;
    logic signed [CB-1:0] p_z;
    logic signed [CB-1:0] q_x;
    logic signed [CB-1:0] q_y;
    logic signed [CB-1:0] q_z;
    logic signed [CB-1:0] r_x;
    logic signed [CB-1:0] r_y;
    logic signed [CB-1:0] r_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CB-1:0] point_x;
    logic signed [CB-1:0] point_y;
    logic signed [CB-1:0] point_z;
  } out_t;

endpackage

/* hdl/strc_alu.sv */
// ----------------------------------------------------------------------------
// strc_alu
// Shared shift-add multiply-accumulate and restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module strc_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  strc_pkg::alu_cmd_t   cmd,
  output strc_pkg::alu_stat_t  stat
);
  import strc_pkg::*;

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic [NBW-1:0]       cnt;
  logic [QB-1:0]        quo;
  alu_op_t              op;
  logic                 neg;

  logic                 last;
  logic                 sub;
  logic signed [AW-1:0] opnd;
  logic signed [AW-1:0] sum;

  always_comb begin
    last = (cnt == NBW'(1));
    if (op == ALU_DIV) begin
      opnd = ma;
      sub  = 1'b1;
    end else begin
      opnd = mb[0] ? ma : '0;
      sub  = neg ^ last;
    end
    sum = acc + (sub ? ~opnd : opnd) + AW'(sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.go) begin
      op  <= cmd.op;
      neg <= cmd.neg;
      cnt <= cmd.nb;
      mb  <= cmd.b;
      quo <= '0;
      if (cmd.op == ALU_DIV) begin
        ma <= AW'(cmd.b) <<< (QB - 1);
      end else begin
        ma <= cmd.a;
      end
      if (cmd.clr) begin
        acc <= '0;
      end
    end else if (cnt != '0) begin
      cnt <= cnt - NBW'(1);
      if (op == ALU_DIV) begin
        if (!sum[AW-1]) begin
          acc <= sum;
        end
        quo <= {quo[QB-2:0], ~sum[AW-1]};
        ma  <= ma >>> 1;
      end else begin
        acc <= sum;
        ma  <= ma <<< 1;
        mb  <= mb >>> 1;
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.acc  = acc;
  assign stat.quo  = quo;

endmodule

/* hdl/strc_store.sv */
// ----------------------------------------------------------------------------
// strc_store
// Triangle corner memories, one per axis, one row per triangle.
// ----------------------------------------------------------------------------
module strc_store #(
  parameter int DEPTH = 4096,
  parameter int IW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  strc_pkg::tri_t   wdata,
  input  logic [IW-1:0]    raddr,
  output strc_pkg::tri_t   rdata
);
  import strc_pkg::*;

  logic [3*CB-1:0] x_mem [DEPTH];
  logic [3*CB-1:0] y_mem [DEPTH];
  logic [3*CB-1:0] z_mem [DEPTH];
  logic [3*CB-1:0] xr, yr, zr;

  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[waddr] <= {wdata.a.x, wdata.b.x, wdata.c.x};
      y_mem[waddr] <= {wdata.a.y, wdata.b.y, wdata.c.y};
      z_mem[waddr] <= {wdata.a.z, wdata.b.z, wdata.c.z};
    end
    xr <= x_mem[raddr];
    yr <= y_mem[raddr];
    zr <= z_mem[raddr];
  end

  assign rdata.a = {xr[3*CB-1:2*CB], yr[3*CB-1:2*CB], zr[3*CB-1:2*CB]};
  assign rdata.b = {xr[2*CB-1:CB], yr[2*CB-1:CB], zr[2*CB-1:CB]};
  assign rdata.c = {xr[CB-1:0], yr[CB-1:0], zr[CB-1:0]};

endmodule

/* hdl/strc_ctrl.sv */
// ----------------------------------------------------------------------------
// strc_ctrl
// Sequencer: steps the shared unit through the per-ray and per-triangle work.
// ----------------------------------------------------------------------------
module strc_ctrl #(
  parameter int CW = 13,
  parameter int IW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  strc_pkg::in_t        in_data,
  input  logic [CW-1:0]        n_tri,
  output logic                 out_valid,
  input  logic                 out_stall,
  output strc_pkg::out_t       out_data,
  output logic [IW-1:0]        raddr,
  input  strc_pkg::tri_t       rdata,
  output strc_pkg::alu_cmd_t   cmd,
  input  strc_pkg::alu_stat_t  stat
);
  import strc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_GO, S_WAIT, S_RD, S_LD, S_FLIP, S_CHK, S_FIN
  } state_t;

  typedef enum logic [5:0] {
    U_L2A, U_L2B, U_L2C, U_EPL,
    U_PV0A, U_PV0B, U_PV1A, U_PV1B, U_PV2A, U_PV2B,
    U_DET0, U_DET1, U_DET2, U_DSQ,
    U_QV0A, U_QV0B, U_QV1A, U_QV1B, U_QV2A, U_QV2B,
    U_UN0, U_UN1, U_UN2, U_VN0, U_VN1, U_VN2, U_TN0, U_TN1, U_TN2,
    U_TSQ, U_TL, U_ED, U_CMPA, U_CMPB,
    U_FA, U_FB, U_FDIV
  } step_t;

  state_t state;
  step_t  step;

  logic signed [CB-1:0]  s [3];
  logic signed [DW-1:0]  d [3];
  logic signed [DW-1:0]  e1 [3];
  logic signed [DW-1:0]  e2 [3];
  logic signed [DW-1:0]  t [3];
  logic signed [PW-1:0]  pv [3];
  logic signed [PW-1:0]  qv [3];
  logic [CB-1:0]         pt [3];
  logic signed [BW-1:0]  l2, epsl2, det, un, vn, tn, best_n, best_d;
  logic signed [D2W-1:0] det2;
  logic signed [AW-1:0]  tmp;
  logic [CW-1:0]         i;
  logic [1:0]            k;
  logic                  found;

  logic [CW-1:0]         i_inc;
  logic                  upd;
  logic                  fnd;
  state_t                tri_state;
  logic signed [DW-1:0]  absd;
  logic [CB-1:0]         pq;
  logic [CB-1:0]         pt_new;
  logic signed [BW-1:0]  uv;
  logic                  reject;

  assign in_stall = (state != S_IDLE);
  assign raddr    = i[IW-1:0];

  always_comb begin
    i_inc     = i + CW'(1);
    upd       = (step == U_CMPB) && stat.acc[AW-1];
    fnd       = found | upd;
    tri_state = (i_inc == n_tri) ? (fnd ? S_GO : S_FIN) : S_RD;
    absd      = d[k][DW-1] ? -d[k] : d[k];
    pq        = CB'(stat.quo);
    pt_new    = d[k][DW-1] ? (CB'(s[k]) - pq) : (CB'(s[k]) + pq);
    uv        = un + vn;
    reject    = un[BW-1] || (un > det) || vn[BW-1] || (uv > det) || tn[BW-1] ||
                (tn == '0);
  end

  always_comb begin
    cmd     = '0;
    cmd.go  = (state == S_GO);
    cmd.op  = ALU_MUL;
    cmd.nb  = NBW'(DW);
    unique case (step)
      U_L2A:  begin cmd.clr = 1'b1; cmd.a = AW'(d[0]); cmd.b = BW'(d[0]); end
      U_L2B:  begin cmd.a = AW'(d[1]); cmd.b = BW'(d[1]); end
      U_L2C:  begin cmd.a = AW'(d[2]); cmd.b = BW'(d[2]); end
      U_EPL:  begin cmd.clr = 1'b1; cmd.a = AW'(l2); cmd.b = EPS_SQ; cmd.nb = NBW'(EW); end
      U_PV0A: begin cmd.clr = 1'b1; cmd.a = AW'(d[1]); cmd.b = BW'(e2[2]); end
      U_PV0B: begin cmd.neg = 1'b1; cmd.a = AW'(d[2]); cmd.b = BW'(e2[1]); end
      U_PV1A: begin cmd.clr = 1'b1; cmd.a = AW'(d[2]); cmd.b = BW'(e2[0]); end
      U_PV1B: begin cmd.neg = 1'b1; cmd.a = AW'(d[0]); cmd.b = BW'(e2[2]); end
      U_PV2A: begin cmd.clr = 1'b1; cmd.a = AW'(d[0]); cmd.b = BW'(e2[1]); end
      U_PV2B: begin cmd.neg = 1'b1; cmd.a = AW'(d[1]); cmd.b = BW'(e2[0]); end
      U_DET0: begin cmd.clr = 1'b1; cmd.a = AW'(pv[0]); cmd.b = BW'(e1[0]); end
      U_DET1: begin cmd.a = AW'(pv[1]); cmd.b = BW'(e1[1]); end
      U_DET2: begin cmd.a = AW'(pv[2]); cmd.b = BW'(e1[2]); end
      U_DSQ:  begin cmd.clr = 1'b1; cmd.a = AW'(det); cmd.b = det; cmd.nb = NBW'(NBIG); end
      U_QV0A: begin cmd.clr = 1'b1; cmd.a = AW'(t[1]); cmd.b = BW'(e1[2]); end
      U_QV0B: begin cmd.neg = 1'b1; cmd.a = AW'(t[2]); cmd.b = BW'(e1[1]); end
      U_QV1A: begin cmd.clr = 1'b1; cmd.a = AW'(t[2]); cmd.b = BW'(e1[0]); end
      U_QV1B: begin cmd.neg = 1'b1; cmd.a = AW'(t[0]); cmd.b = BW'(e1[2]); end
      U_QV2A: begin cmd.clr = 1'b1; cmd.a = AW'(t[0]); cmd.b = BW'(e1[1]); end
      U_QV2B: begin cmd.neg = 1'b1; cmd.a = AW'(t[1]); cmd.b = BW'(e1[0]); end
      U_UN0:  begin cmd.clr = 1'b1; cmd.a = AW'(pv[0]); cmd.b = BW'(t[0]); end
      U_UN1:  begin cmd.a = AW'(pv[1]); cmd.b = BW'(t[1]); end
      U_UN2:  begin cmd.a = AW'(pv[2]); cmd.b = BW'(t[2]); end
      U_VN0:  begin cmd.clr = 1'b1; cmd.a = AW'(qv[0]); cmd.b = BW'(d[0]); end
      U_VN1:  begin cmd.a = AW'(qv[1]); cmd.b = BW'(d[1]); end
      U_VN2:  begin cmd.a = AW'(qv[2]); cmd.b = BW'(d[2]); end
      U_TN0:  begin cmd.clr = 1'b1; cmd.a = AW'(qv[0]); cmd.b = BW'(e2[0]); end
      U_TN1:  begin cmd.a = AW'(qv[1]); cmd.b = BW'(e2[1]); end
      U_TN2:  begin cmd.a = AW'(qv[2]); cmd.b = BW'(e2[2]); end
      U_TSQ:  begin cmd.clr = 1'b1; cmd.a = AW'(tn); cmd.b = tn; cmd.nb = NBW'(NBIG); end
      U_TL:   begin cmd.clr = 1'b1; cmd.a = tmp; cmd.b = l2; cmd.nb = NBW'(LW); end
      U_ED:   begin cmd.clr = 1'b1; cmd.a = AW'(det2); cmd.b = EPS_SQ; cmd.nb = NBW'(EW); end
      U_CMPA: begin
        cmd.clr = 1'b1; cmd.a = AW'(tn); cmd.b = best_d; cmd.nb = NBW'(NBIG);
      end
      U_CMPB: begin
        cmd.neg = 1'b1; cmd.a = AW'(best_n); cmd.b = det; cmd.nb = NBW'(NBIG);
      end
      U_FA:   begin cmd.clr = 1'b1; cmd.a = AW'(best_n) <<< 1; cmd.b = BW'(absd); end
      U_FB:   begin cmd.a = AW'(best_d); cmd.b = BW'(1); cmd.nb = NBW'(2); end
      U_FDIV: begin cmd.op = ALU_DIV; cmd.b = best_d <<< 1; cmd.nb = NBW'(QB); end
      default: cmd.nb = NBW'(DW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= U_L2A;
      out_valid <= 1'b0;
      found     <= 1'b0;
      i         <= '0;
      k         <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_data.operation == OP_CAST) begin
            s[0]  <= in_data.p_x;
            s[1]  <= in_data.p_y;
            s[2]  <= in_data.p_z;
            d[0]  <= DW'(in_data.q_x) - DW'(in_data.p_x);
            d[1]  <= DW'(in_data.q_y) - DW'(in_data.p_y);
            d[2]  <= DW'(in_data.q_z) - DW'(in_data.p_z);
            pt[0] <= in_data.q_x;
            pt[1] <= in_data.q_y;
            pt[2] <= in_data.q_z;
            found <= 1'b0;
            step  <= U_L2A;
            state <= S_GO;
          end
        end
        S_GO: state <= S_WAIT;
        S_WAIT: begin
          if (!stat.busy) begin
            state <= S_GO;
            step  <= step_t'(step + 6'd1);
            unique case (step)
              U_L2C: begin
                l2 <= stat.acc[BW-1:0];
                if (n_tri == '0 || stat.acc == '0) begin
                  state <= S_FIN;
                end
              end
              U_EPL: begin
                epsl2  <= stat.acc[BW-1:0];
                best_n <= BW'(1);
                best_d <= BW'(1);
                i      <= '0;
                state  <= S_RD;
              end
              U_PV0B: pv[0] <= stat.acc[PW-1:0];
              U_PV1B: pv[1] <= stat.acc[PW-1:0];
              U_PV2B: pv[2] <= stat.acc[PW-1:0];
              U_DET2: det <= stat.acc[BW-1:0];
              U_DSQ: begin
                det2 <= stat.acc[D2W-1:0];
                if ((stat.acc <<< DET_SH) < AW'(epsl2)) begin
                  i     <= i_inc;
                  k     <= '0;
                  step  <= U_FA;
                  state <= tri_state;
                end
              end
              U_QV0B: qv[0] <= stat.acc[PW-1:0];
              U_QV1B: qv[1] <= stat.acc[PW-1:0];
              U_QV2B: qv[2] <= stat.acc[PW-1:0];
              U_UN2: un <= stat.acc[BW-1:0];
              U_VN2: vn <= stat.acc[BW-1:0];
              U_TN2: begin
                tn    <= stat.acc[BW-1:0];
                state <= S_FLIP;
              end
              U_TSQ: tmp <= stat.acc;
              U_TL:  tmp <= stat.acc;
              U_ED: begin
                if ((tmp <<< TN_SH) <= stat.acc) begin
                  i     <= i_inc;
                  k     <= '0;
                  step  <= U_FA;
                  state <= tri_state;
                end
              end
              U_CMPB: begin
                if (upd) begin
                  best_n <= tn;
                  best_d <= det;
                  found  <= 1'b1;
                end
                i     <= i_inc;
                k     <= '0;
                step  <= U_FA;
                state <= tri_state;
              end
              U_FDIV: begin
                pt[k] <= pt_new;
                if (k == 2'd2) begin
                  state <= S_FIN;
                end else begin
                  k    <= k + 2'd1;
                  step <= U_FA;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: state <= S_LD;
        S_LD: begin
          e1[0] <= DW'(rdata.b.x) - DW'(rdata.a.x);
          e1[1] <= DW'(rdata.b.y) - DW'(rdata.a.y);
          e1[2] <= DW'(rdata.b.z) - DW'(rdata.a.z);
          e2[0] <= DW'(rdata.c.x) - DW'(rdata.a.x);
          e2[1] <= DW'(rdata.c.y) - DW'(rdata.a.y);
          e2[2] <= DW'(rdata.c.z) - DW'(rdata.a.z);
          t[0]  <= DW'(s[0]) - DW'(rdata.a.x);
          t[1]  <= DW'(s[1]) - DW'(rdata.a.y);
          t[2]  <= DW'(s[2]) - DW'(rdata.a.z);
          step  <= U_PV0A;
          state <= S_GO;
        end
        S_FLIP: begin
          if (det[BW-1]) begin
            det <= -det;
            un  <= -un;
            vn  <= -vn;
            tn  <= -tn;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          if (reject) begin
            i     <= i_inc;
            k     <= '0;
            step  <= U_FA;
            state <= tri_state;
          end else begin
            step  <= U_TSQ;
            state <= S_GO;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            out_data.hit     <= found;
            out_data.point_x <= pt[0];
            out_data.point_y <= pt[1];
            out_data.point_z <= pt[2];
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/segment_triangle_raycaster_top.sv */
// ----------------------------------------------------------------------------
// segment_triangle_raycaster_top
// Segment ray against a table of triangles, nearest hit, Q15.8 fixed point.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// in       in   in_t: load one triangle, or cast one segment
// out      out  out_t: hit flag and point, one beat per cast
// cfg      in   triangle_count, written on cfg_we, no handshake
//
// A load is written to the corner memories when accepted. A cast runs a setup,
// then the work per loaded triangle (less when rejected early) and, on a hit,
// the hit point, all on the one-bit-a-cycle shared arithmetic unit.
// in_stall is high from a cast beat until its result is registered; one
// result may wait in the output register while the next beat is taken.
// Reset is synchronous; the corner memories are not cleared.
// ----------------------------------------------------------------------------
module segment_triangle_raycaster_top #(
  parameter int MAX_TRIANGLES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  strc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output strc_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [strc_pkg::CFG_W-1:0]   cfg_data
);
  import strc_pkg::*;

  localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW = $clog2(MAX_TRIANGLES + 1);

  logic [CFG_W-1:0] triangle_count;
  logic [CW-1:0]    n_tri;
  logic             we;
  tri_t             wdata;
  tri_t             rdata;
  logic [IW-1:0]    raddr;
  alu_cmd_t         cmd;
  alu_stat_t        stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_count <= '0;
    end else if (cfg_we) begin
      triangle_count <= cfg_data;
    end
  end

  assign n_tri = (32'(triangle_count) > 32'(MAX_TRIANGLES)) ?
                 CW'(MAX_TRIANGLES) : CW'(triangle_count);

  assign we = in_valid && !in_stall && (in_data.operation == OP_LOAD) &&
              (32'(in_data.triangle_index) < 32'(MAX_TRIANGLES));

  assign wdata.a = {in_data.p_x, in_data.p_y, in_data.p_z};
  assign wdata.b = {in_data.q_x, in_data.q_y, in_data.q_z};
  assign wdata.c = {in_data.r_x, in_data.r_y, in_data.r_z};

  strc_store #(
    .DEPTH (MAX_TRIANGLES),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (IW'(in_data.triangle_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  strc_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  strc_ctrl #(
    .CW (CW),
    .IW (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .n_tri     (n_tri),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .raddr     (raddr),
    .rdata     (rdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* bench/raycast_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_checker
// Watches the in, out and cfg channels of the raycaster. It keeps its own
// triangle table and triangle count, computes the expected hit flag and point
// for every accepted cast beat with exact wide integer arithmetic, and
// compares each accepted result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module raycast_checker
  import strc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_t                in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_t               out_data,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int TABLE_DEPTH = 4096;
  localparam logic signed [383:0] EPS_WIDE = 384'sd1844674407;

  typedef logic signed [383:0] wide_t;

  tri_t             tri_table [0:TABLE_DEPTH-1];
  logic [CFG_W-1:0] tri_count;
  out_t             hits_due [$];

  assign pending = hits_due.size();

  function automatic void cross3(input wide_t a [3], input wide_t b [3],
                                 output wide_t r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dot3(input wide_t a [3], input wide_t b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic out_t trace_segment(input in_t beat);
    wide_t src [3], dst [3], dir [3];
    wide_t ca [3], cb [3], cc [3], e1 [3], e2 [3], tv [3], pv [3], qv [3];
    wide_t len2, det, det2, un, vn, tn, best_n, best_d, off, quo, pt;
    int    n;
    bit    found;
    out_t  r;
    src = '{wide_t'(beat.p_x), wide_t'(beat.p_y), wide_t'(beat.p_z)};
    dst = '{wide_t'(beat.q_x), wide_t'(beat.q_y), wide_t'(beat.q_z)};
    for (int k = 0; k < 3; k++) dir[k] = dst[k] - src[k];
    r.hit = 1'b0;
    r.point_x = beat.q_x;
    r.point_y = beat.q_y;
    r.point_z = beat.q_z;
    len2 = dot3(dir, dir);
    n = (tri_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(tri_count);
    if (n == 0 || len2 == 0) return r;
    best_n = 1;
    best_d = 1;
    found = 0;
    for (int i = 0; i < n; i++) begin
      ca = '{wide_t'(tri_table[i].a.x), wide_t'(tri_table[i].a.y), wide_t'(tri_table[i].a.z)};
      cb = '{wide_t'(tri_table[i].b.x), wide_t'(tri_table[i].b.y), wide_t'(tri_table[i].b.z)};
      cc = '{wide_t'(tri_table[i].c.x), wide_t'(tri_table[i].c.y), wide_t'(tri_table[i].c.z)};
      for (int k = 0; k < 3; k++) begin
        e1[k] = cb[k] - ca[k];
        e2[k] = cc[k] - ca[k];
        tv[k] = src[k] - ca[k];
      end
      cross3(dir, e2, pv);
      det = dot3(e1, pv);
      det2 = det * det;
      if ((det2 <<< 32) < EPS_WIDE * len2) continue;
      cross3(tv, e1, qv);
      un = dot3(tv, pv);
      vn = dot3(dir, qv);
      tn = dot3(e2, qv);
      if (det < 0) begin
        det = -det;
        un = -un;
        vn = -vn;
        tn = -tn;
      end
      if (un < 0 || un > det) continue;
      if (vn < 0 || un + vn > det) continue;
      if (tn <= 0) continue;
      if (((tn * tn * len2) <<< 48) <= EPS_WIDE * det2) continue;
      if (tn * best_d < best_n * det) begin
        best_n = tn;
        best_d = det;
        found = 1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        off = dir[k] * best_n;
        quo = (((off < 0) ? -off : off) * 2 + best_d) / (best_d * 2);
        pt = src[k] + ((off < 0) ? -quo : quo);
        if (k == 0) r.point_x = pt[CB-1:0];
        else if (k == 1) r.point_y = pt[CB-1:0];
        else r.point_z = pt[CB-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_t due;
    if (rst) begin
      tri_count <= '0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hits_due.size() == 0) begin
          $error("result beat with no cast outstanding");
          fail_count++;
        end else begin
          due = hits_due.pop_front();
          if (out_data.hit !== due.hit) begin
            $error("hit: expected %0d, got %0d", due.hit, out_data.hit);
            fail_count++;
          end
          if (out_data.point_x !== due.point_x) begin
            $error("point_x: expected %0d, got %0d", due.point_x, out_data.point_x);
            fail_count++;
          end
          if (out_data.point_y !== due.point_y) begin
            $error("point_y: expected %0d, got %0d", due.point_y, out_data.point_y);
            fail_count++;
          end
          if (out_data.point_z !== due.point_z) begin
            $error("point_z: expected %0d, got %0d", due.point_z, out_data.point_z);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_LOAD) begin
          tri_table[in_data.triangle_index] <= '{
            a: '{in_data.p_x, in_data.p_y, in_data.p_z},
            b: '{in_data.q_x, in_data.q_y, in_data.q_z},
            c: '{in_data.r_x, in_data.r_y, in_data.r_z}};
        end else begin
          hits_due = {hits_due, trace_segment(in_data)};
        end
      end
      if (cfg_we) tri_count <= cfg_data;
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the raycaster with triangle loads and segment casts: a directed set
// of hits, misses, degenerate and parallel triangles, edge and vertex hits,
// zero length and not-ready casts and coordinate extremes, then rounds of
// random triangles with rays aimed through them plus random noise. Both
// channels idle in random bursts; checker failures or a timeout fail the run.
// ----------------------------------------------------------------------------
module tb_top;
  import strc_pkg::*;

  localparam int LIMIT = 10000000;
  localparam int U = 256;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               cycles;
  bit               calm;
  bit               squeeze;

  segment_triangle_raycaster_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  raycast_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("segment_triangle_raycaster_top verification failed");
        $finish;
      end
    end
  end

  function automatic int srand(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic in_t load_beat(int idx, int ax, int ay, int az, int bx, int by,
                                    int bz, int cx, int cy, int cz);
    in_t b;
    b = '{OP_LOAD, 12'(idx), CB'(ax), CB'(ay), CB'(az), CB'(bx), CB'(by), CB'(bz),
          CB'(cx), CB'(cy), CB'(cz)};
    return b;
  endfunction

  function automatic in_t cast_beat(int px, int py, int pz, int qx, int qy, int qz);
    in_t b;
    b = '{OP_CAST, 12'($urandom), CB'(px), CB'(py), CB'(pz), CB'(qx), CB'(qy), CB'(qz),
          CB'($urandom), CB'($urandom), CB'($urandom)};
    return b;
  endfunction

  function automatic in_t noise_beat();
    in_t b;
    b = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    b.operation = OP_LOAD;
    return b;
  endfunction

  task automatic send(in_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic set_count(int value);
    wait (pending == 0);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    bit held;
    held = 0;
    out_stall = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1;
        out_stall = 1'b1;
        repeat (20000) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    int cx, cy, cz, n;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    calm = 0;
    squeeze = 0;
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed table: plane z=0, a farther plane, a degenerate, a parallel
    // one, one behind the source, and duplicates for ties
    send(load_beat(0, -100*U, -100*U, 0, 100*U, -100*U, 0, -100*U, 100*U, 0));
    send(load_beat(1, -100*U, -100*U, -5*U, 100*U, -100*U, -5*U, -100*U, 100*U, -5*U));
    send(load_beat(2, 7*U, 7*U, 7*U, 7*U, 7*U, 7*U, 7*U, 7*U, 7*U));
    send(load_beat(3, 0, -50*U, -50*U, 0, 50*U, -50*U, 0, 0, 50*U));
    send(load_beat(4, -100*U, -100*U, 20*U, 100*U, -100*U, 20*U, -100*U, 100*U, 20*U));
    for (int i = 5; i < 8; i++)
      send(load_beat(i, -100*U, -100*U, 0, 100*U, -100*U, 0, -100*U, 100*U, 0));
    send(load_beat(4095, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                   8388607, -8388608, 8388607));
    send(cast_beat(-10*U, -10*U, 10*U, -10*U, -10*U, -10*U));
    set_count(8);
    send(cast_beat(-10*U, -10*U, 10*U, -10*U, -10*U, -10*U));
    send(cast_beat(3*U, 4*U, 5*U, 3*U, 4*U, 5*U));
    send(cast_beat(-10*U, -10*U, 10*U, -10*U, -10*U, 5*U));
    send(cast_beat(-100*U, 0, 10*U, -100*U, 0, -10*U));
    send(cast_beat(-100*U, -100*U, 10*U, -100*U, -100*U, -10*U));
    send(cast_beat(-10*U + 3, -10*U + 1, -10*U, -10*U - 5, -10*U + 7, 10*U));
    send(cast_beat(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send(cast_beat(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    set_count(8191);
    send(load_beat(4095, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                   -8388608, 8388607, -8388608));
    set_count(1);
    send(cast_beat(1*U, 2*U, 30*U, 1*U, 2*U, -30*U));

    for (int round = 0; round < 6; round++) begin
      n = $urandom_range(1, 6);
      set_count(n);
      if (round == 0) squeeze = 1;
      if (round == 5) calm = 1;
      cx = srand(1 << 21);
      cy = srand(1 << 21);
      cz = srand(1 << 21);
      for (int i = 0; i < n; i++)
        send(load_beat(i, cx + srand(1 << 16), cy + srand(1 << 16), cz + srand(1 << 16),
                       cx + srand(1 << 16), cy + srand(1 << 16), cz + srand(1 << 16),
                       cx + srand(1 << 16), cy + srand(1 << 16), cz + srand(1 << 16)));
      for (int j = 0; j < 17; j++) begin
        int sel, ox, oy, oz;
        sel = $urandom_range(0, 19);
        if (sel < 15) begin
          ox = srand(1 << 17);
          oy = srand(1 << 17);
          oz = srand(1 << 17);
          send(cast_beat(cx + ox, cy + oy, cz + oz, cx - ox + srand(1 << 12),
                         cy - oy + srand(1 << 12), cz - oz + srand(1 << 12)));
        end else if (sel < 17) begin
          send(noise_beat());
        end else begin
          send(cast_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        end
      end
    end

    wait (pending == 0);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("segment_triangle_raycaster_top verification clean");
    end else begin
      $display("segment_triangle_raycaster_top verification failed");
    end
    $finish;
  end

endmodule
